[hw/rtl/itlr_pkg.sv]
// ----------------------------------------------------------------------------
// itlr_pkg
// shared constants, types and helpers of the thin lens ray refraction block
// ----------------------------------------------------------------------------
package itlr_pkg;

  // fixed point format of directions
  localparam int DIR_FRAC_BITS = 30;
  localparam logic [63:0] ONE_SQ = 64'd1 << (2 * DIR_FRAC_BITS);
  localparam logic signed [31:0] DIR_ONE = 32'sd1 <<< DIR_FRAC_BITS;

  // configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_FOCAL = 1'b0;
  localparam logic REG_APER  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_SKIP  = 2'd0;
  localparam logic [1:0] ST_REFR  = 2'd1;
  localparam logic [1:0] ST_PRUNE = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  // pipelined root and divider geometry
  localparam int ROOT_W    = 32;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_LAT   = DIV_NUM_W;

  // stages before the output register
  localparam int VLD_LEN = 4 + SQRT_LAT + 1 + DIV_LAT + 7 + SQRT_LAT + DIV_LAT;

  // normalised magnitude width (top bit sits at position 30)
  localparam int NRM_W = 31;
  localparam logic [5:0] NRM_POS = 6'd30;

  // front half sideband: hit point, input direction and early flags
  typedef struct packed {
    logic act;
    logic outside;
    logic graze;
    logic negx;
    logic negy;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] hz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } fr_t;

  // back half sideband: flags, signs, input direction and normalised magnitudes
  typedef struct packed {
    logic act;
    logic outside;
    logic graze;
    logic mzero;
    logic [2:0] sgn;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [NRM_W-1:0] m0;
    logic [NRM_W-1:0] m1;
    logic [NRM_W-1:0] m2;
  } bk_t;

  // magnitude of a signed 32 bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (~u + 32'd1) : u;
  endfunction

endpackage

[hw/rtl/ideal_thin_lens_ray_refract.sv]
// ----------------------------------------------------------------------------
// ideal_thin_lens_ray_refract
// refracts one ray per unstalled cycle through an ideal thin lens of circular aperture
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with ray_active, hit_x/y/z, in_dir_x/y/z
//   output channel: out_valid / out_stall with out_dir_x/y/z and ray_status
//   apb port: register 0 focal_length at 0x0, register 1 aperture_radius at 0x4
//   pipeline: two bit-per-stage root units (32 stages each), two bit-per-stage
//   divider banks (64 stages each), plus the multiply and normalise stages
//   throughput: one item per cycle while the output is not stalled
//   stall: when the output register holds an item and out_stall is high the
//   whole pipeline holds and in_stall rises in the same cycle; nothing is lost
//   reset: clears every valid bit and returns focal_length and aperture_radius
//   to 1.0; unenforced by the block, registers are to be written by the user
//   only while no item is in flight
// ----------------------------------------------------------------------------
module ideal_thin_lens_ray_refract (
  input  logic clk,
  input  logic rst,
  // input channel
  input  logic in_valid,
  output logic in_stall,
  input  logic ray_active,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic signed [31:0] hit_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  // output channel
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] out_dir_x,
  output logic signed [31:0] out_dir_y,
  output logic signed [31:0] out_dir_z,
  output logic [1:0] ray_status,
  // configuration
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [itlr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int SL = itlr_pkg::SQRT_LAT;
  localparam int DL = itlr_pkg::DIV_LAT;
  localparam int VL = itlr_pkg::VLD_LEN;
  localparam int NW = itlr_pkg::NRM_W;

  logic signed [31:0] focal_length;
  logic [30:0] aperture_radius;
  logic adv;
  logic [VL-1:0] vld;

  // configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == itlr_pkg::REG_APER) ? {1'b0, aperture_radius} : focal_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length    <= 32'sd65536;
      aperture_radius <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == itlr_pkg::REG_FOCAL) begin
        focal_length <= pwdata;
      end else begin
        aperture_radius <= pwdata[30:0];
      end
    end
  end

  // global advance: the pipeline holds only while a finished item waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[VL-2:0], in_valid};
      out_valid <= vld[VL-1];
    end
  end

  // ---------------- front: aperture and grazing tests ----------------
  itlr_pkg::fr_t fr_s1, fr_s2, fr_s3, fr_s4, fr_a;
  itlr_pkg::fr_t fr_s4_next, fr_a_next;
  itlr_pkg::fr_t fr_sq [0:SL-1];
  itlr_pkg::fr_t fr_dv [0:DL-1];
  logic [63:0] hx2, hy2, dx2, dy2, r2, s3;
  logic [61:0] rr_s2, rr_s3;
  logic [63:0] rad_s4;
  logic [31:0] dz_root;
  logic [63:0] pf_x, pf_y;
  logic [31:0] den_a;
  logic [63:0] quot_x, quot_y;

  // early flags joined to the sideband
  always_comb begin
    fr_s4_next         = fr_s3;
    fr_s4_next.outside = (r2 > {2'b00, rr_s3});
    fr_s4_next.graze   = (s3 >= itlr_pkg::ONE_SQ);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // input register
      fr_s1.act     <= ray_active;
      fr_s1.outside <= 1'b0;
      fr_s1.graze   <= 1'b0;
      fr_s1.negx    <= 1'b0;
      fr_s1.negy    <= 1'b0;
      fr_s1.hx      <= hit_x;
      fr_s1.hy      <= hit_y;
      fr_s1.hz      <= hit_z;
      fr_s1.dx      <= in_dir_x;
      fr_s1.dy      <= in_dir_y;
      fr_s1.dz      <= in_dir_z;
      // squares
      hx2   <= 64'(itlr_pkg::mag32(fr_s1.hx)) * 64'(itlr_pkg::mag32(fr_s1.hx));
      hy2   <= 64'(itlr_pkg::mag32(fr_s1.hy)) * 64'(itlr_pkg::mag32(fr_s1.hy));
      dx2   <= 64'(itlr_pkg::mag32(fr_s1.dx)) * 64'(itlr_pkg::mag32(fr_s1.dx));
      dy2   <= 64'(itlr_pkg::mag32(fr_s1.dy)) * 64'(itlr_pkg::mag32(fr_s1.dy));
      rr_s2 <= 62'(aperture_radius) * 62'(aperture_radius);
      fr_s2 <= fr_s1;
      // sums
      r2    <= hx2 + hy2;
      s3    <= dx2 + dy2;
      rr_s3 <= rr_s2;
      fr_s3 <= fr_s2;
      // compares and root argument
      fr_s4  <= fr_s4_next;
      rad_s4 <= itlr_pkg::ONE_SQ - s3;
    end
  end

  // dz = floor(sqrt(1 - dx^2 - dy^2))
  itlr_sqrt u_sqrt_dz (
    .clk  (clk),
    .en   (adv),
    .rad  (rad_s4),
    .root (dz_root)
  );

  // sideband through the root unit and the aim dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      fr_sq[0] <= fr_s4;
      for (int k = 1; k < SL; k++) begin
        fr_sq[k] <= fr_sq[k-1];
      end
      fr_dv[0] <= fr_a;
      for (int k = 1; k < DL; k++) begin
        fr_dv[k] <= fr_dv[k-1];
      end
    end
  end

  // signs of the aim coordinates
  always_comb begin
    fr_a_next      = fr_sq[SL-1];
    fr_a_next.negx = focal_length[31] ^ fr_sq[SL-1].dx[31];
    fr_a_next.negy = focal_length[31] ^ fr_sq[SL-1].dy[31];
  end

  // focal length times direction, signs kept apart
  always_ff @(posedge clk) begin
    if (adv) begin
      pf_x <= 64'(itlr_pkg::mag32(focal_length)) * 64'(itlr_pkg::mag32(fr_sq[SL-1].dx));
      pf_y <= 64'(itlr_pkg::mag32(focal_length)) * 64'(itlr_pkg::mag32(fr_sq[SL-1].dy));
      den_a <= dz_root;
      fr_a  <= fr_a_next;
    end
  end

  // aim point x and y on the focal plane
  itlr_div u_div_ax (
    .clk  (clk),
    .en   (adv),
    .num  (pf_x),
    .den  (den_a),
    .quot (quot_x)
  );

  itlr_div u_div_ay (
    .clk  (clk),
    .en   (adv),
    .num  (pf_y),
    .den  (den_a),
    .quot (quot_y)
  );

  // ---------------- back: aim vector and normalisation ----------------
  itlr_pkg::fr_t fr_b;
  logic signed [64:0] v0_b, v1_b, v2_b;
  logic signed [64:0] v0_d, v1_d, v2_d;
  itlr_pkg::bk_t bk_c, bk_d, bk_e, bk_f, bk_g, bk_h;
  itlr_pkg::bk_t bk_e_next, bk_g_next;
  itlr_pkg::bk_t bk_sq [0:SL-1];
  itlr_pkg::bk_t bk_dv [0:DL-1];
  logic [63:0] mg_c [0:2];
  logic [63:0] mg_d [0:2];
  logic [63:0] mg_e [0:2];
  logic [63:0] or_c;
  logic [7:0] gnz_d, gnz_d_n;
  logic [2:0] gpos_d [0:7];
  logic [2:0] gpos_d_n [0:7];
  logic [5:0] pos_e, pos_e_n;
  logic mzero_e_n;
  logic [NW-1:0] mn_f [0:2];
  logic [61:0] sq_g [0:2];
  logic [63:0] sum_h;
  logic [31:0] n_root;
  logic [63:0] quot_n [0:2];

  // aim vector minus hit point
  always_comb begin
    logic signed [64:0] qx, qy, fz;
    qx = $signed({2'b00, quot_x[62:0]});
    qy = $signed({2'b00, quot_y[62:0]});
    fz = $signed({{33{focal_length[31]}}, focal_length});
    v0_d = (fr_dv[DL-1].negx ? -qx : qx)
         - $signed({{33{fr_dv[DL-1].hx[31]}}, fr_dv[DL-1].hx});
    v1_d = (fr_dv[DL-1].negy ? -qy : qy)
         - $signed({{33{fr_dv[DL-1].hy[31]}}, fr_dv[DL-1].hy});
    v2_d = -fz - $signed({{33{fr_dv[DL-1].hz[31]}}, fr_dv[DL-1].hz});
  end

  // leading one per byte of the magnitude union
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      gnz_d_n[g]  = |or_c[8*g +: 8];
      gpos_d_n[g] = 3'd0;
      for (int j = 0; j < 8; j++) begin
        if (or_c[8*g + j]) begin
          gpos_d_n[g] = 3'(j);
        end
      end
    end
  end

  // highest non-empty byte gives the leading one position
  always_comb begin
    pos_e_n   = 6'd0;
    mzero_e_n = 1'b1;
    for (int g = 0; g < 8; g++) begin
      if (gnz_d[g]) begin
        pos_e_n   = {3'(g), gpos_d[g]};
        mzero_e_n = 1'b0;
      end
    end
  end

  // zero vector flag and normalised magnitudes joined to the sideband
  always_comb begin
    bk_e_next       = bk_d;
    bk_e_next.mzero = mzero_e_n;
    bk_g_next       = bk_f;
    bk_g_next.m0    = mn_f[0];
    bk_g_next.m1    = mn_f[1];
    bk_g_next.m2    = mn_f[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // aim vector
      v0_b <= v0_d;
      v1_b <= v1_d;
      v2_b <= v2_d;
      fr_b <= fr_dv[DL-1];
      // magnitudes and signs
      mg_c[0] <= v0_b[64] ? 64'(-v0_b) : v0_b[63:0];
      mg_c[1] <= v1_b[64] ? 64'(-v1_b) : v1_b[63:0];
      mg_c[2] <= v2_b[64] ? 64'(-v2_b) : v2_b[63:0];
      or_c    <= (v0_b[64] ? 64'(-v0_b) : v0_b[63:0])
               | (v1_b[64] ? 64'(-v1_b) : v1_b[63:0])
               | (v2_b[64] ? 64'(-v2_b) : v2_b[63:0]);
      bk_c.act     <= fr_b.act;
      bk_c.outside <= fr_b.outside;
      bk_c.graze   <= fr_b.graze;
      bk_c.mzero   <= 1'b0;
      bk_c.sgn     <= {v2_b[64], v1_b[64], v0_b[64]};
      bk_c.dx      <= fr_b.dx;
      bk_c.dy      <= fr_b.dy;
      bk_c.dz      <= fr_b.dz;
      bk_c.m0      <= '0;
      bk_c.m1      <= '0;
      bk_c.m2      <= '0;
      // byte search
      gnz_d <= gnz_d_n;
      for (int g = 0; g < 8; g++) begin
        gpos_d[g] <= gpos_d_n[g];
      end
      mg_d <= mg_c;
      bk_d <= bk_c;
      // position select
      pos_e <= pos_e_n;
      mg_e  <= mg_d;
      bk_e  <= bk_e_next;
      // common shift so the largest magnitude has its top bit at 30
      for (int i = 0; i < 3; i++) begin
        if (pos_e > itlr_pkg::NRM_POS) begin
          mn_f[i] <= NW'(mg_e[i] >> (pos_e - itlr_pkg::NRM_POS));
        end else begin
          mn_f[i] <= NW'(mg_e[i] << (itlr_pkg::NRM_POS - pos_e));
        end
      end
      bk_f <= bk_e;
      // squares of the normalised magnitudes
      for (int i = 0; i < 3; i++) begin
        sq_g[i] <= 62'(mn_f[i]) * 62'(mn_f[i]);
      end
      bk_g <= bk_g_next;
      // sum of squares
      sum_h <= 64'(sq_g[0]) + 64'(sq_g[1]) + 64'(sq_g[2]);
      bk_h  <= bk_g;
    end
  end

  // vector length
  itlr_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (adv),
    .rad  (sum_h),
    .root (n_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      bk_sq[0] <= bk_h;
      for (int k = 1; k < SL; k++) begin
        bk_sq[k] <= bk_sq[k-1];
      end
      bk_dv[0] <= bk_sq[SL-1];
      for (int k = 1; k < DL; k++) begin
        bk_dv[k] <= bk_dv[k-1];
      end
    end
  end

  // normalising dividers, one per component
  itlr_div u_div_n0 (
    .clk  (clk),
    .en   (adv),
    .num  (64'(bk_sq[SL-1].m0) << itlr_pkg::DIR_FRAC_BITS),
    .den  (n_root),
    .quot (quot_n[0])
  );

  itlr_div u_div_n1 (
    .clk  (clk),
    .en   (adv),
    .num  (64'(bk_sq[SL-1].m1) << itlr_pkg::DIR_FRAC_BITS),
    .den  (n_root),
    .quot (quot_n[1])
  );

  itlr_div u_div_n2 (
    .clk  (clk),
    .en   (adv),
    .num  (64'(bk_sq[SL-1].m2) << itlr_pkg::DIR_FRAC_BITS),
    .den  (n_root),
    .quot (quot_n[2])
  );

  // output register: status and chosen direction
  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (!bk_dv[DL-1].act) begin
        ray_status <= itlr_pkg::ST_SKIP;
      end else if (bk_dv[DL-1].outside) begin
        ray_status <= itlr_pkg::ST_PRUNE;
      end else if (bk_dv[DL-1].graze || bk_dv[DL-1].mzero) begin
        ray_status <= itlr_pkg::ST_ERR;
      end else begin
        ray_status <= itlr_pkg::ST_REFR;
      end
      if (bk_dv[DL-1].act && !bk_dv[DL-1].outside && !bk_dv[DL-1].graze
          && !bk_dv[DL-1].mzero) begin
        out_dir_x <= bk_dv[DL-1].sgn[0] ? -quot_n[0][31:0] : quot_n[0][31:0];
        out_dir_y <= bk_dv[DL-1].sgn[1] ? -quot_n[1][31:0] : quot_n[1][31:0];
        out_dir_z <= bk_dv[DL-1].sgn[2] ? -quot_n[2][31:0] : quot_n[2][31:0];
      end else begin
        out_dir_x <= bk_dv[DL-1].dx;
        out_dir_y <= bk_dv[DL-1].dy;
        out_dir_z <= bk_dv[DL-1].dz;
      end
    end
  end

  // ---------------- assertions ----------------
  // a refracted direction is a unit vector, so neither x nor z exceeds one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && ray_status == itlr_pkg::ST_REFR |->
      out_dir_x <= itlr_pkg::DIR_ONE && out_dir_x >= -itlr_pkg::DIR_ONE &&
      out_dir_z <= itlr_pkg::DIR_ONE && out_dir_z >= -itlr_pkg::DIR_ONE)
    else $error("refracted direction out of unit range");

  // a held pipeline keeps every valid bit in place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> vld == $past(vld))
    else $error("valid bits moved while the pipeline was held");

  // the last stage always reaches the output register when it advances
  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld[VL-1] && adv |=> out_valid)
    else $error("item lost at the output register");

endmodule

[hw/rtl/itlr_sqrt.sv]
// ----------------------------------------------------------------------------
// itlr_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module itlr_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [itlr_pkg::RAD_W-1:0] rad,
  output logic [itlr_pkg::ROOT_W-1:0] root
);

  localparam int RW = itlr_pkg::ROOT_W;
  localparam int AW = itlr_pkg::RAD_W;

  logic [RW+1:0] rem_q  [0:RW-1];
  logic [RW-1:0] root_q [0:RW-1];
  logic [AW-1:0] arg_q  [0:RW-1];
  logic [RW+1:0] rem_d  [0:RW-1];
  logic [RW-1:0] root_d [0:RW-1];
  logic [AW-1:0] arg_d  [0:RW-1];

  // one restoring root step per stage
  always_comb begin
    logic [RW+1:0] cur_rem;
    logic [RW-1:0] cur_root;
    logic [AW-1:0] cur_arg;
    logic [RW+3:0] rsh;
    logic [RW+3:0] trial;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        cur_rem  = '0;
        cur_root = '0;
        cur_arg  = rad;
      end else begin
        cur_rem  = rem_q[k-1];
        cur_root = root_q[k-1];
        cur_arg  = arg_q[k-1];
      end
      rsh   = {cur_rem, cur_arg[AW-1:AW-2]};
      trial = {2'b00, cur_root, 2'b01};
      if (rsh >= trial) begin
        rem_d[k]  = (RW+2)'(rsh - trial);
        root_d[k] = {cur_root[RW-2:0], 1'b1};
      end else begin
        rem_d[k]  = rsh[RW+1:0];
        root_d[k] = {cur_root[RW-2:0], 1'b0};
      end
      arg_d[k] = {cur_arg[AW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        arg_q[k]  <= arg_d[k];
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

[hw/rtl/itlr_div.sv]
// ----------------------------------------------------------------------------
// itlr_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module itlr_div (
  input  logic clk,
  input  logic en,
  input  logic [itlr_pkg::DIV_NUM_W-1:0] num,
  input  logic [itlr_pkg::DIV_DEN_W-1:0] den,
  output logic [itlr_pkg::DIV_NUM_W-1:0] quot
);

  localparam int NW = itlr_pkg::DIV_NUM_W;
  localparam int DW = itlr_pkg::DIV_DEN_W;

  logic [DW-1:0] rem_q [0:NW-1];
  logic [NW-1:0] nq_q  [0:NW-1];
  logic [DW-1:0] den_q [0:NW-1];
  logic [DW-1:0] rem_d [0:NW-1];
  logic [NW-1:0] nq_d  [0:NW-1];
  logic [DW-1:0] den_d [0:NW-1];

  // shift in one numerator bit, subtract where it fits
  always_comb begin
    logic [DW-1:0] cur_rem;
    logic [NW-1:0] cur_nq;
    logic [DW-1:0] cur_den;
    logic [DW:0]   part;
    logic [DW:0]   diff;
    logic          qbit;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        cur_rem = '0;
        cur_nq  = num;
        cur_den = den;
      end else begin
        cur_rem = rem_q[k-1];
        cur_nq  = nq_q[k-1];
        cur_den = den_q[k-1];
      end
      part = {cur_rem, cur_nq[NW-1]};
      diff = part - {1'b0, cur_den};
      qbit = (part >= {1'b0, cur_den});
      rem_d[k] = qbit ? diff[DW-1:0] : part[DW-1:0];
      nq_d[k]  = {cur_nq[NW-2:0], qbit};
      den_d[k] = cur_den;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quot = nq_q[NW-1];

endmodule
